// ===== hw/rtl/dsmcc_dsi_ior_parser_macros.svh =====
// ----------------------------------------------------------------------------
// DSI IOR parser assertion macros
// Concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef DSMCC_DSI_IOR_PARSER_MACROS_SVH
`define DSMCC_DSI_IOR_PARSER_MACROS_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset
`define DSI_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included
`define DSI_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSI_ASSERT(name, clk, rst_n, prop, msg)
`define DSI_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/dsi_pkg.sv =====
// ----------------------------------------------------------------------------
// DSI IOR parser package
// Beat types, result status codes, register indexes and fixed field sizes.
// ----------------------------------------------------------------------------
package dsi_pkg;

  // Fixed message layout
  localparam logic [31:0] HDR_BYTES       = 32'd12;
  localparam logic [31:0] SERVER_ID_BYTES = 32'd20;
  localparam logic [7:0]  VER_MAJOR       = 8'h01;
  localparam logic [7:0]  VER_MINOR       = 8'h00;
  localparam logic [31:0] LITE_COMPONENTS = 32'd2;
  localparam logic [31:0] MAX_KEY_BYTES   = 32'd4;

  // Register reset values
  localparam logic [7:0]  ADAPT_RESET = 8'd0;
  localparam logic [31:0] PTAG_RESET  = 32'h4953_4F06;
  localparam logic [31:0] LTAG_RESET  = 32'h4953_4F50;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ADAPT = 2'd0,
    CFG_PTAG  = 2'd1,
    CFG_LTAG  = 2'd2
  } cfg_idx_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PROFILES   = 3'd1,
    ST_PTAG       = 3'd2,
    ST_COMPONENTS = 3'd3,
    ST_LTAG       = 3'd4,
    ST_VERSION    = 3'd5,
    ST_KEY_LEN    = 3'd6,
    ST_TRUNC      = 3'd7
  } status_e;

  // Input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;
  } in_item_t;

  // Result beat
  typedef struct packed {
    status_e     status;
    logic [31:0] carousel_id;
    logic [15:0] module_id;
    logic [31:0] object_key;
    logic        key_present;
  } out_item_t;

  // Configuration registers
  typedef struct packed {
    logic [7:0]  adaptation_bytes;
    logic [31:0] profile_tag_value;
    logic [31:0] location_tag_value;
  } cfg_t;

  // Front queue head toward the parser
  typedef struct packed {
    logic     valid;
    logic     start;
    logic     last;
    in_item_t beat;
  } front_head_t;

endpackage

// ===== hw/rtl/dsi_front.sv =====
// ----------------------------------------------------------------------------
// DSI front queue
// Two-entry queue that takes input beats and flags message start/end.
// ----------------------------------------------------------------------------
module dsi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  dsi_pkg::in_item_t   beat_i,
  output dsi_pkg::front_head_t head_o,
  input  logic                take_i
);

  dsi_pkg::in_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_take;

  assign full    = (cnt_q == 2'd2);
  assign do_push = push && !full;
  assign do_take = take_i && (cnt_q != 2'd0);

  // Head of queue, classified
  always_comb begin
    head_o.valid = (cnt_q != 2'd0);
    head_o.beat  = mem_q[rd_ptr_q];
    head_o.start = mem_q[rd_ptr_q].first_byte;
    head_o.last  = mem_q[rd_ptr_q].final_byte;
  end

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_take;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= beat_i;
    end
  end

endmodule

// ===== hw/rtl/dsi_back.sv =====
// ----------------------------------------------------------------------------
// DSI back end
// Byte-wise IOR parser with a two-entry result queue on its output.
// ----------------------------------------------------------------------------
module dsi_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dsi_pkg::cfg_t        cfg_i,
  input  dsi_pkg::front_head_t head_i,
  output logic                 take_o,
  output logic                 empty,
  input  logic                 pop,
  output dsi_pkg::out_item_t   result_o
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_DONE, PH_HDR, PH_LEN1, PH_LEN2, PH_TLEN, PH_TSKIP,
    PH_PCNT, PH_PTAG, PH_BODYLEN, PH_BORDER, PH_LCNT, PH_LTAG, PH_OLEN,
    PH_CAR, PH_MOD, PH_VER, PH_KLEN, PH_KEY, PH_BTAG, PH_BLEN, PH_BSKIP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] car_q, car_d;
  logic [15:0] mod_q, mod_d;
  logic [31:0] key_q, key_d;
  logic [2:0]  klen_q, klen_d;

  // Effective state after a possible restart
  phase_e      eff_phase;
  logic [31:0] eff_cnt, eff_acc, eff_car, eff_key;
  logic [15:0] eff_mod;
  logic [2:0]  eff_klen;
  logic [31:0] acc_new, cnt_new;
  logic        active;

  logic                st_valid;
  dsi_pkg::status_e    st;
  dsi_pkg::out_item_t  res;

  // Result queue
  dsi_pkg::out_item_t rq_q [2];
  logic       rq_wr_q, rq_rd_q;
  logic [1:0] rq_cnt_q;
  logic       rq_push, rq_pop;

  assign take_o = head_i.valid && (rq_cnt_q != 2'd2);

  // Restart on first byte of a message
  always_comb begin
    if (head_i.start) begin
      eff_phase = PH_HDR;
      eff_cnt   = dsi_pkg::HDR_BYTES + dsi_pkg::SERVER_ID_BYTES
                  + {24'd0, cfg_i.adaptation_bytes};
      eff_acc   = '0;
      eff_car   = '0;
      eff_mod   = '0;
      eff_key   = '0;
      eff_klen  = '0;
    end else begin
      eff_phase = phase_q;
      eff_cnt   = cnt_q;
      eff_acc   = acc_q;
      eff_car   = car_q;
      eff_mod   = mod_q;
      eff_key   = key_q;
      eff_klen  = klen_q;
    end
    active  = (eff_phase != PH_IDLE) && (eff_phase != PH_DONE);
    acc_new = {eff_acc[23:0], head_i.beat.data_byte};
    cnt_new = (eff_cnt != 32'd0) ? eff_cnt - 32'd1 : 32'd0;
  end

  // Field completion and checks
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    car_d    = car_q;
    mod_d    = mod_q;
    key_d    = key_q;
    klen_d   = klen_q;
    st_valid = 1'b0;
    st       = dsi_pkg::ST_OK;
    if (take_o && active) begin
      phase_d = eff_phase;
      cnt_d   = cnt_new;
      acc_d   = acc_new;
      car_d   = eff_car;
      mod_d   = eff_mod;
      key_d   = eff_key;
      klen_d  = eff_klen;
      if (cnt_new == 32'd0) begin
        acc_d = '0;
        unique case (eff_phase)
          PH_HDR: begin
            phase_d = PH_LEN1; cnt_d = 32'd2;
          end
          PH_LEN1: begin
            if (acc_new == 32'd0) begin
              phase_d = PH_LEN2; cnt_d = 32'd2;
            end else begin
              phase_d = PH_TLEN; cnt_d = 32'd4;
            end
          end
          PH_LEN2: begin
            phase_d = PH_TLEN; cnt_d = 32'd4;
          end
          PH_TLEN: begin
            if (acc_new == 32'd0) begin
              phase_d = PH_PCNT; cnt_d = 32'd4;
            end else begin
              phase_d = PH_TSKIP; cnt_d = acc_new;
            end
          end
          PH_TSKIP: begin
            phase_d = PH_PCNT; cnt_d = 32'd4;
          end
          PH_PCNT: begin
            if (acc_new > 32'd1) begin
              st_valid = 1'b1; st = dsi_pkg::ST_PROFILES;
            end else begin
              phase_d = PH_PTAG; cnt_d = 32'd4;
            end
          end
          PH_PTAG: begin
            if (acc_new != cfg_i.profile_tag_value) begin
              st_valid = 1'b1; st = dsi_pkg::ST_PTAG;
            end else begin
              phase_d = PH_BODYLEN; cnt_d = 32'd4;
            end
          end
          PH_BODYLEN: begin
            phase_d = PH_BORDER; cnt_d = 32'd1;
          end
          PH_BORDER: begin
            phase_d = PH_LCNT; cnt_d = 32'd1;
          end
          PH_LCNT: begin
            if (acc_new != dsi_pkg::LITE_COMPONENTS) begin
              st_valid = 1'b1; st = dsi_pkg::ST_COMPONENTS;
            end else begin
              phase_d = PH_LTAG; cnt_d = 32'd4;
            end
          end
          PH_LTAG: begin
            if (acc_new != cfg_i.location_tag_value) begin
              st_valid = 1'b1; st = dsi_pkg::ST_LTAG;
            end else begin
              phase_d = PH_OLEN; cnt_d = 32'd1;
            end
          end
          PH_OLEN: begin
            phase_d = PH_CAR; cnt_d = 32'd4;
          end
          PH_CAR: begin
            car_d = acc_new; phase_d = PH_MOD; cnt_d = 32'd2;
          end
          PH_MOD: begin
            mod_d = acc_new[15:0]; phase_d = PH_VER; cnt_d = 32'd2;
          end
          PH_VER: begin
            if (acc_new[15:8] != dsi_pkg::VER_MAJOR ||
                acc_new[7:0] != dsi_pkg::VER_MINOR) begin
              st_valid = 1'b1; st = dsi_pkg::ST_VERSION;
            end else begin
              phase_d = PH_KLEN; cnt_d = 32'd1;
            end
          end
          PH_KLEN: begin
            if (acc_new > dsi_pkg::MAX_KEY_BYTES) begin
              st_valid = 1'b1; st = dsi_pkg::ST_KEY_LEN;
            end else begin
              klen_d = acc_new[2:0];
              if (acc_new == 32'd0) begin
                phase_d = PH_BTAG; cnt_d = 32'd4;
              end else begin
                phase_d = PH_KEY; cnt_d = acc_new;
              end
            end
          end
          PH_KEY: begin
            key_d = acc_new; phase_d = PH_BTAG; cnt_d = 32'd4;
          end
          PH_BTAG: begin
            phase_d = PH_BLEN; cnt_d = 32'd1;
          end
          PH_BLEN: begin
            if (acc_new == 32'd0) begin
              st_valid = 1'b1; st = dsi_pkg::ST_OK;
            end else begin
              phase_d = PH_BSKIP; cnt_d = acc_new;
            end
          end
          PH_BSKIP: begin
            st_valid = 1'b1; st = dsi_pkg::ST_OK;
          end
          default: begin
            phase_d = PH_DONE;
          end
        endcase
      end
      // early end of message
      if (!st_valid && head_i.last) begin
        st_valid = 1'b1;
        st       = dsi_pkg::ST_TRUNC;
      end
      if (st_valid) begin
        phase_d = PH_DONE;
      end
    end
  end

  // Result beat; payload zeroed on failure
  always_comb begin
    res        = '0;
    res.status = st;
    if (st == dsi_pkg::ST_OK) begin
      res.carousel_id = car_d;
      res.module_id   = mod_d;
      res.key_present = (klen_d != 3'd0);
      res.object_key  = (klen_d != 3'd0) ? key_d : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      car_q   <= '0;
      mod_q   <= '0;
      key_q   <= '0;
      klen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      car_q   <= car_d;
      mod_q   <= mod_d;
      key_q   <= key_d;
      klen_q  <= klen_d;
    end
  end

  // Result queue control
  assign rq_push  = take_o && st_valid;
  assign empty    = (rq_cnt_q == 2'd0);
  assign rq_pop   = pop && !empty;
  assign result_o = rq_q[rq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      rq_wr_q  <= rq_wr_q ^ rq_push;
      rq_rd_q  <= rq_rd_q ^ rq_pop;
      rq_cnt_q <= rq_cnt_q + {1'b0, rq_push} - {1'b0, rq_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rq_push) begin
      rq_q[rq_wr_q] <= res;
    end
  end

endmodule

// ===== hw/rtl/dsmcc_dsi_ior_parser.sv =====
// ----------------------------------------------------------------------------
// DSM-CC DSI service gateway IOR parser
// Parses a download-server-initiate message byte by byte, at most one result each.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the result queue has room, set by the parser's per-byte state update.
// Result path: a deciding byte is registered in the front queue, and its result
//   is registered in the result queue before it reaches the ports.
// Reset: queues empty, parser idle, registers back to their default values.
`include "dsmcc_dsi_ior_parser_macros.svh"

module dsmcc_dsi_ior_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  dsi_pkg::in_item_t  data_i,
  output logic               empty,
  input  logic               pop,
  output dsi_pkg::out_item_t result_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);

  dsi_pkg::cfg_t        cfg_q, cfg_d;
  dsi_pkg::front_head_t head;
  logic                 take;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dsi_pkg::CFG_ADAPT: cfg_d.adaptation_bytes   = cfg_data_i[7:0];
        dsi_pkg::CFG_PTAG:  cfg_d.profile_tag_value  = cfg_data_i;
        dsi_pkg::CFG_LTAG:  cfg_d.location_tag_value = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adaptation_bytes   <= dsi_pkg::ADAPT_RESET;
      cfg_q.profile_tag_value  <= dsi_pkg::PTAG_RESET;
      cfg_q.location_tag_value <= dsi_pkg::LTAG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dsi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .beat_i (data_i),
    .head_o (head),
    .take_i (take)
  );

  dsi_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .head_i   (head),
    .take_o   (take),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  // Checks
  `DSI_ASSERT(a_fail_zero, clk_i, rst_ni, (!empty && result_o.status != dsi_pkg::ST_OK) |-> (result_o.carousel_id == 32'd0 && result_o.module_id == 16'd0 && result_o.object_key == 32'd0 && !result_o.key_present), "failing result carries payload")
  `DSI_ASSERT(a_key_absent, clk_i, rst_ni, (!empty && !result_o.key_present) |-> (result_o.object_key == 32'd0), "object key set without key")
  `DSI_ASSERT(a_push_lands, clk_i, rst_ni, (push && !full) |=> head.valid, "accepted beat missing from front queue")
  `DSI_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> (empty && !full), "queues not empty in reset")

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// DSI IOR parser testbench
// Feeds download-server-initiate messages one byte per beat, some well formed
// and some broken, noisy, cut short or restarted. A byte-level model of the
// service gateway IOR walk predicts each result, and every result beat is
// checked field by field. The configuration changes between phases, and both
// sides stall at random in the first four phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dsi_pkg::*;

  // Parse phases of the model
  typedef enum logic [4:0] {
    S_IDLE, S_DONE, S_HEADER, S_PRIV_LEN, S_PRIV_LEN2, S_TYPE_LEN, S_TYPE_SKIP,
    S_PROF_COUNT, S_PROF_TAG, S_BODY_LEN, S_BYTE_ORDER, S_COMP_COUNT,
    S_LOC_TAG, S_LOC_LEN, S_CAROUSEL, S_MODULE, S_VERSION, S_KEY_LEN, S_KEY,
    S_BIND_TAG, S_BIND_LEN, S_BIND_SKIP
  } ior_phase_e;

  // Ways a generated message is damaged
  typedef enum int {
    F_NONE, F_PROFILES, F_PTAG, F_COMPONENTS, F_LTAG, F_VERSION, F_KEY_LEN,
    F_TRUNC, F_TRUNC_VERSION, F_RESTART
  } fault_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  in_item_t   in_beat = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_item_t  out_beat;
  logic       cfg_we = 1'b0;
  cfg_idx_e   cfg_idx = CFG_ADAPT;
  logic [31:0] cfg_data = '0;

  // Register copies
  logic [7:0]  adapt_cfg = ADAPT_RESET;
  logic [31:0] ptag_cfg  = PTAG_RESET;
  logic [31:0] ltag_cfg  = LTAG_RESET;

  // Model state
  ior_phase_e  ior_phase = S_IDLE;
  logic [31:0] ior_left = '0;
  logic [31:0] ior_acc = '0;
  logic [31:0] ior_carousel = '0;
  logic [15:0] ior_module = '0;
  logic [31:0] ior_key = '0;
  logic [2:0]  ior_key_len = '0;

  in_item_t    beats_to_send[$];
  out_item_t   ior_results_due[$];
  logic [7:0]  msg_bytes[$];
  int          mismatches = 0;
  int          tx_idle_pct = 25;
  int          rx_idle_pct = 83;

  dsmcc_dsi_ior_parser dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .data_i     (in_beat),
    .empty      (empty),
    .pop        (pop),
    .result_o   (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---- model ---------------------------------------------------------------

  function automatic void goto_phase(ior_phase_e p, logic [31:0] n);
    ior_phase = p;
    ior_left  = n;
    ior_acc   = '0;
  endfunction

  // One accepted beat; queues the result it decides, if any
  function automatic void ior_take_byte(in_item_t it);
    logic [31:0] a;
    bit          fin;
    status_e     st;
    out_item_t   r;
    fin = 1'b0;
    st  = ST_OK;
    if (it.first_byte) begin
      ior_carousel = '0;
      ior_module   = '0;
      ior_key      = '0;
      ior_key_len  = '0;
      goto_phase(S_HEADER, HDR_BYTES + {24'd0, adapt_cfg} + SERVER_ID_BYTES);
    end
    // outside a message: ignored
    if (ior_phase == S_IDLE || ior_phase == S_DONE) return;
    ior_acc = {ior_acc[23:0], it.data_byte};
    if (ior_left != 0) ior_left--;
    if (ior_left == 0) begin
      a = ior_acc;
      case (ior_phase)
        S_HEADER:     goto_phase(S_PRIV_LEN, 2);
        S_PRIV_LEN:   if (a == 0) goto_phase(S_PRIV_LEN2, 2); else goto_phase(S_TYPE_LEN, 4);
        S_PRIV_LEN2:  goto_phase(S_TYPE_LEN, 4);
        S_TYPE_LEN:   if (a == 0) goto_phase(S_PROF_COUNT, 4); else goto_phase(S_TYPE_SKIP, a);
        S_TYPE_SKIP:  goto_phase(S_PROF_COUNT, 4);
        S_PROF_COUNT: begin
          if (a > 1) begin
            fin = 1'b1;
            st  = ST_PROFILES;
          end else goto_phase(S_PROF_TAG, 4);
        end
        S_PROF_TAG: begin
          if (a != ptag_cfg) begin
            fin = 1'b1;
            st  = ST_PTAG;
          end else goto_phase(S_BODY_LEN, 4);
        end
        S_BODY_LEN:   goto_phase(S_BYTE_ORDER, 1);
        S_BYTE_ORDER: goto_phase(S_COMP_COUNT, 1);
        S_COMP_COUNT: begin
          if (a != LITE_COMPONENTS) begin
            fin = 1'b1;
            st  = ST_COMPONENTS;
          end else goto_phase(S_LOC_TAG, 4);
        end
        S_LOC_TAG: begin
          if (a != ltag_cfg) begin
            fin = 1'b1;
            st  = ST_LTAG;
          end else goto_phase(S_LOC_LEN, 1);
        end
        S_LOC_LEN:    goto_phase(S_CAROUSEL, 4);
        S_CAROUSEL: begin
          ior_carousel = a;
          goto_phase(S_MODULE, 2);
        end
        S_MODULE: begin
          ior_module = a[15:0];
          goto_phase(S_VERSION, 2);
        end
        S_VERSION: begin
          if (a[15:8] != VER_MAJOR || a[7:0] != VER_MINOR) begin
            fin = 1'b1;
            st  = ST_VERSION;
          end else goto_phase(S_KEY_LEN, 1);
        end
        S_KEY_LEN: begin
          if (a > MAX_KEY_BYTES) begin
            fin = 1'b1;
            st  = ST_KEY_LEN;
          end else begin
            ior_key_len = a[2:0];
            if (a == 0) goto_phase(S_BIND_TAG, 4); else goto_phase(S_KEY, a);
          end
        end
        S_KEY: begin
          ior_key = a;
          goto_phase(S_BIND_TAG, 4);
        end
        S_BIND_TAG:   goto_phase(S_BIND_LEN, 1);
        S_BIND_LEN:   if (a == 0) fin = 1'b1; else goto_phase(S_BIND_SKIP, a);
        S_BIND_SKIP:  fin = 1'b1;
        default:      ior_phase = S_DONE;
      endcase
    end
    // early end of the message
    if (!fin && it.final_byte) begin
      fin = 1'b1;
      st  = ST_TRUNC;
    end
    if (fin) begin
      ior_phase = S_DONE;
      r = '0;
      r.status = st;
      if (st == ST_OK) begin
        r.carousel_id = ior_carousel;
        r.module_id   = ior_module;
        r.object_key  = (ior_key_len != 0) ? ior_key : '0;
        r.key_present = (ior_key_len != 0);
      end
      ior_results_due.push_back(r);
    end
  endfunction

  // ---- stimulus helpers ----------------------------------------------------

  function automatic void send_beat(logic [7:0] d, bit is_first, bit is_last);
    in_item_t b;
    b.data_byte  = d;
    b.first_byte = is_first;
    b.final_byte = is_last;
    beats_to_send.push_back(b);
  endfunction

  function automatic void put_be(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) msg_bytes.push_back(v[8*i +: 8]);
  endfunction

  // fill < 0 gives random bytes, else the constant byte
  function automatic void put_fill(int n, int fill);
    for (int i = 0; i < n; i++)
      msg_bytes.push_back(fill < 0 ? 8'($urandom) : fill[7:0]);
  endfunction

  // Builds one message for the current settings and queues its beats
  function automatic void send_msg(fault_e fault, int type_len, int key_len, int bind_len,
                                   bit split_len, int trail, int fill);
    logic [31:0] v;
    int          ver_at;
    int          cut;
    msg_bytes.delete();
    // header, adaptation bytes, server id
    put_fill(int'(HDR_BYTES) + int'(adapt_cfg) + int'(SERVER_ID_BYTES), fill);
    // private data length; a zero length is followed by a second one
    if (split_len) begin
      put_be('0, 2);
      put_be($urandom, 2);
    end else put_be($urandom_range(16'hFFFF, 1), 2);
    put_be(type_len, 4);
    put_fill(type_len, fill);
    v = $urandom_range(1);
    if (fault == F_PROFILES) begin
      v = $urandom;
      if (v < 2) v = 2;
    end
    put_be(v, 4);
    v = ptag_cfg;
    if (fault == F_PTAG) v ^= 32'($urandom) | (32'd1 << $urandom_range(31));
    put_be(v, 4);
    // body length, byte order
    put_fill(5, fill);
    v = LITE_COMPONENTS;
    if (fault == F_COMPONENTS) begin
      v = $urandom_range(255);
      if (v == LITE_COMPONENTS) v = 3;
    end
    put_be(v, 1);
    v = ltag_cfg;
    if (fault == F_LTAG) v ^= 32'($urandom) | (32'd1 << $urandom_range(31));
    put_be(v, 4);
    // location length, carousel id, module id
    put_fill(7, fill);
    ver_at = msg_bytes.size();
    v = {16'd0, VER_MAJOR, VER_MINOR};
    if (fault == F_VERSION) begin
      v = $urandom_range(16'hFFFF);
      if (v[15:0] == {VER_MAJOR, VER_MINOR}) v[0] = 1'b1;
    end
    put_be(v, 2);
    v = key_len;
    if (fault == F_KEY_LEN) v = $urandom_range(255, 5);
    put_be(v, 1);
    put_fill(key_len, fill);
    // binder tag, length, body, then trailing bytes
    put_fill(4, fill);
    put_be(bind_len, 1);
    put_fill(bind_len + trail, fill);
    cut = msg_bytes.size();
    case (fault)
      F_TRUNC:         cut = $urandom_range(cut, 1);
      F_TRUNC_VERSION: cut = ver_at + 1;
      F_RESTART:       cut = $urandom_range(cut - 1, 1);
      default:         ;
    endcase
    for (int i = 0; i < cut; i++)
      send_beat(msg_bytes[i], i == 0, (i == cut - 1) && (fault != F_RESTART));
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ADAPT: adapt_cfg = val[7:0];
      CFG_PTAG:  ptag_cfg  = val;
      default:   ltag_cfg  = val;
    endcase
  endtask

  // Wait until all beats are in and all results out, then let the pipe settle
  task automatic wait_idle();
    while (beats_to_send.size() != 0 || push || ior_results_due.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // ---- driver --------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        ior_take_byte(in_beat);
        beats_to_send.delete(0);
      end
      // hold a beat that was not taken
      if (!(push && full)) begin
        if (beats_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          push    <= 1'b1;
          in_beat <= beats_to_send[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---- monitor -------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  out_item_t want_beat;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (ior_results_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none actual %0h",
                   $time, out_beat);
          mismatches++;
        end else begin
          want_beat = ior_results_due.pop_front();
          check_field("status", want_beat.status, out_beat.status);
          check_field("carousel_id", want_beat.carousel_id, out_beat.carousel_id);
          check_field("module_id", want_beat.module_id, out_beat.module_id);
          check_field("object_key", want_beat.object_key, out_beat.object_key);
          check_field("key_present", want_beat.key_present, out_beat.key_present);
        end
      end
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---- sequence ------------------------------------------------------------
  initial begin
    fault_e f;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int seg = 0; seg < 6; seg++) begin
      // idling: sender light first, then receiver light, then none
      case (seg / 2)
        0:       begin tx_idle_pct = 25; rx_idle_pct = 83; end
        1:       begin tx_idle_pct = 83; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      case (seg)
        1: begin
          write_reg(CFG_ADAPT, 32'd255);
          write_reg(CFG_PTAG, 32'hFFFF_FFFF);
          write_reg(CFG_LTAG, 32'h0);
        end
        2: begin
          write_reg(CFG_ADAPT, 32'd1);
          write_reg(CFG_PTAG, 32'h0);
          write_reg(CFG_LTAG, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(CFG_ADAPT, $urandom_range(16));
          write_reg(CFG_PTAG, $urandom);
          write_reg(CFG_LTAG, $urandom);
        end
        4: begin
          write_reg(CFG_ADAPT, 32'd0);
          write_reg(CFG_PTAG, PTAG_RESET);
          write_reg(CFG_LTAG, LTAG_RESET);
        end
        5: begin
          write_reg(CFG_ADAPT, $urandom_range(8, 2));
          write_reg(CFG_PTAG, $urandom);
          write_reg(CFG_LTAG, $urandom);
        end
        default: ;
      endcase

      if (seg == 0) begin
        // directed: all-ones and all-zeros content, every failure status
        send_msg(F_NONE, 3, 4, 5, 1'b1, 2, 8'hFF);
        send_msg(F_NONE, 0, 0, 0, 1'b0, 0, 8'h00);
        send_msg(F_NONE, 1, 1, 1, 1'b0, 0, -1);
        send_msg(F_PROFILES, 2, 2, 2, 1'b0, 0, -1);
        send_msg(F_PTAG, 0, 2, 2, 1'b0, 0, -1);
        send_msg(F_COMPONENTS, 0, 2, 2, 1'b0, 0, -1);
        send_msg(F_LTAG, 0, 2, 2, 1'b0, 0, -1);
        send_msg(F_VERSION, 0, 2, 2, 1'b0, 0, -1);
        send_msg(F_KEY_LEN, 0, 2, 2, 1'b0, 0, -1);
        // message ends right after the version major byte
        send_msg(F_TRUNC_VERSION, 0, 2, 2, 1'b0, 0, -1);
        send_msg(F_TRUNC, 4, 3, 3, 1'b1, 0, -1);
        // stray bytes after a result, one marked final
        send_beat(8'hFF, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        // abandoned message, then a clean one
        send_msg(F_RESTART, 2, 3, 1, 1'b0, 0, -1);
        send_msg(F_NONE, 2, 3, 1, 1'b0, 3, -1);
        // lone beat that both starts and ends a message
        send_beat(8'hA5, 1'b1, 1'b1);
      end

      // random messages, most of them well formed
      for (int m = 0; m < (seg == 1 ? 4 : 10); m++) begin
        if ($urandom_range(9) == 0) begin
          for (int k = $urandom_range(6, 1); k > 0; k--)
            send_beat($urandom, $urandom_range(7) == 0, $urandom_range(3) == 0);
        end
        f = ($urandom_range(1) == 0) ? F_NONE : fault_e'($urandom_range(F_RESTART));
        send_msg(f,
                 ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1),
                 $urandom_range(4),
                 ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(6),
                 $urandom_range(3) == 0,
                 $urandom_range(3),
                 -1);
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
